@@ src/assert_macros.svh @@
// assertion macros used by the allocator top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AR(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define ASSERT_NR(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_AR(lbl, clk, rst_n, prop)
`define ASSERT_NR(lbl, clk, prop)
`endif
`endif

@@ src/bfpa_pkg.sv @@
// constants, types and helpers of the best-fit page allocator
`timescale 1ns / 1ps
package bfpa_pkg;
	localparam int PAGE_BYTES   = 4096;
	localparam int MAX_PAGES    = 256;
	localparam int HEADER_BYTES = 24;

	localparam int ADDR_W     = 20;
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int PAGE_W     = $clog2(MAX_PAGES);
	localparam int LEN_W      = PAGE_W + 1;
	localparam int ALU_W      = LEN_W + 1;
	localparam int NEED_W     = ADDR_W + 2;
	localparam int NEEDP_W    = NEED_W - PAGE_SHIFT;
	localparam int CMP_W      = NEEDP_W + LEN_W;
	localparam int FULL_W     = ((PAGE_W + PAGE_SHIFT > ADDR_W) ? PAGE_W + PAGE_SHIFT : ADDR_W) + 1;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_OOM      = 2'd1;
	localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

	typedef struct packed {
		logic              func;
		logic [ADDR_W-1:0] size_bytes;
		logic [ADDR_W-1:0] payload_address;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] result_address;
		logic [1:0]        status;
	} rsp_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t          op;
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
	} alu_req_t;

	function automatic logic [ADDR_W-1:0] payload_of(input logic [PAGE_W-1:0] page);
		logic [FULL_W-1:0] full;
		full = (FULL_W'(page) << PAGE_SHIFT) + FULL_W'(HEADER_BYTES);
		return full[ADDR_W-1:0];
	endfunction
endpackage

@@ src/bfpa_ram.sv @@
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module bfpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

@@ src/bfpa_alu.sv @@
// shared add and subtract unit for page pointers and chunk lengths
`timescale 1ns / 1ps
module bfpa_alu (
	input  bfpa_pkg::alu_req_t             req,
	output logic [bfpa_pkg::ALU_W-1:0]     y
);
	always_comb begin
		case (req.op)
			bfpa_pkg::ALU_ADD: y = req.a + req.b;
			bfpa_pkg::ALU_SUB: y = req.a - req.b;
			default:           y = req.a + req.b;
		endcase
	end
endmodule

@@ src/best_fit_page_allocator.sv @@
// top level: sequencer and heap top of the best-fit page allocator
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Page-granular best-fit heap manager. After reset a clearing pass writes every chunk entry,
// with req_stall high, before the first request word is taken. Chunk start, in-use flag and
// length of each page live in one ram with a registered read. One request word is taken at
// a time, and req_stall stays high until its response word has been formed. An allocate walks
// the chunk list from page 0 to the heap top, one chunk per cycle through the ram and the
// shared adder, then takes the best fit or grows the heap top, splitting off spare pages.
// A free refuses a malformed address at once, and one naming no allocated chunk after reading
// its entry; else it merges a free next chunk, walks back page by page to the previous chunk
// start (if any), merges it if free, and lowers the heap top under a free tail. A response
// waits in the output register while the next request is taken; a second one waits for it.
module best_fit_page_allocator (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  bfpa_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output bfpa_pkg::rsp_t rsp
);
	typedef enum logic [9:0] {
		ST_IDLE       = 10'b0000000001,
		ST_CLEAR      = 10'b0000000010,
		ST_ALC_SCAN   = 10'b0000000100,
		ST_ALC_COMMIT = 10'b0000001000,
		ST_ALC_SPLIT  = 10'b0000010000,
		ST_FRE_RDP    = 10'b0000100000,
		ST_FRE_RDN    = 10'b0001000000,
		ST_FRE_SRCH   = 10'b0010000000,
		ST_FRE_TOP    = 10'b0100000000,
		ST_DONE       = 10'b1000000000
	} state_t;

	typedef struct packed {
		logic                       begins;
		logic                       in_use;
		logic [bfpa_pkg::LEN_W-1:0] pages;
	} chunk_t;

	state_t                              state_q;
	logic [bfpa_pkg::LEN_W-1:0]          top_q;
	logic [bfpa_pkg::LEN_W-1:0]          p_q;
	logic [bfpa_pkg::LEN_W-1:0]          rp_q;
	logic [bfpa_pkg::LEN_W-1:0]          spare_q;
	logic [bfpa_pkg::LEN_W-1:0]          len_p_q;
	logic [bfpa_pkg::PAGE_W-1:0]         best_q;
	logic [bfpa_pkg::PAGE_W-1:0]         n_q;
	logic [bfpa_pkg::PAGE_W-1:0]         q_q;
	logic                                q_rd_q;
	logic                                n_end_q;
	logic                                found_q;
	logic [bfpa_pkg::ADDR_W-1:0]         res_addr_q;
	logic [1:0]                          res_status_q;
	logic                                rsp_valid_q;
	bfpa_pkg::rsp_t                      rsp_q;

	bfpa_pkg::alu_req_t                  alu_req;
	logic [bfpa_pkg::ALU_W-1:0]          alu_y;

	logic                                ram_we;
	logic [bfpa_pkg::PAGE_W-1:0]         ram_waddr;
	chunk_t                              ram_wdata;
	logic [bfpa_pkg::PAGE_W-1:0]         ram_raddr;
	chunk_t                              ram_rdata;
	logic [bfpa_pkg::LEN_W-1:0]          len_eff;

	logic [bfpa_pkg::NEED_W-1:0]         need_sum;
	logic [bfpa_pkg::NEEDP_W-1:0]        need_pages;
	logic                                need_oom;
	logic [bfpa_pkg::LEN_W-1:0]          rp_in;

	logic [bfpa_pkg::ADDR_W-1:0]         off;
	logic [bfpa_pkg::ADDR_W-1:0]         pg;
	logic [bfpa_pkg::PAGE_W-1:0]         pg_idx;
	logic                                addr_ok;
	logic                                p_live;

	logic [bfpa_pkg::PAGE_W-1:0]         p_idx;
	logic [bfpa_pkg::PAGE_W-1:0]         y_idx;
	logic [bfpa_pkg::PAGE_W-1:0]         top_idx;
	logic                                walk_end;
	logic                                fits;
	logic [bfpa_pkg::LEN_W-1:0]          spare_w;
	logic                                better;
	logic                                heap_full;
	logic                                n_ok;
	logic                                q_stop;
	logic                                q_merge;

	bfpa_alu u_alu (
		.req (alu_req),
		.y   (alu_y)
	);

	bfpa_ram #(
		.WIDTH ($bits(chunk_t)),
		.DEPTH (bfpa_pkg::MAX_PAGES)
	) u_chunk_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// request decode
	assign need_sum   = bfpa_pkg::NEED_W'(req.size_bytes)
		+ bfpa_pkg::NEED_W'(bfpa_pkg::HEADER_BYTES)
		+ bfpa_pkg::NEED_W'(bfpa_pkg::PAGE_BYTES - 1);
	assign need_pages = need_sum[bfpa_pkg::NEED_W-1:bfpa_pkg::PAGE_SHIFT];
	assign need_oom   = bfpa_pkg::CMP_W'(need_pages) > bfpa_pkg::CMP_W'(bfpa_pkg::MAX_PAGES);
	assign rp_in      = (need_pages == '0) ? bfpa_pkg::LEN_W'(1) : bfpa_pkg::LEN_W'(need_pages);

	assign off     = req.payload_address - bfpa_pkg::ADDR_W'(bfpa_pkg::HEADER_BYTES);
	assign pg      = off >> bfpa_pkg::PAGE_SHIFT;
	assign pg_idx  = pg[bfpa_pkg::PAGE_W-1:0];
	assign addr_ok = (req.payload_address >= bfpa_pkg::ADDR_W'(bfpa_pkg::HEADER_BYTES))
		&& (off[bfpa_pkg::PAGE_SHIFT-1:0] == '0)
		&& (pg < bfpa_pkg::ADDR_W'(top_q));

	// step conditions
	assign len_eff   = (ram_rdata.pages == '0) ? bfpa_pkg::LEN_W'(1) : ram_rdata.pages;
	assign p_idx     = p_q[bfpa_pkg::PAGE_W-1:0];
	assign y_idx     = alu_y[bfpa_pkg::PAGE_W-1:0];
	assign top_idx   = top_q[bfpa_pkg::PAGE_W-1:0];
	assign walk_end  = alu_y >= bfpa_pkg::ALU_W'(top_q);
	assign p_live    = ram_rdata.begins && ram_rdata.in_use;
	assign fits      = ram_rdata.begins && !ram_rdata.in_use && (len_eff >= rp_q);
	assign spare_w   = len_eff - rp_q;
	assign better    = fits && (!found_q || (spare_w < spare_q));
	assign heap_full = alu_y > bfpa_pkg::ALU_W'(bfpa_pkg::MAX_PAGES);
	assign n_ok      = !n_end_q && ram_rdata.begins && !ram_rdata.in_use;
	assign q_stop    = q_rd_q && (ram_rdata.begins || (q_q == '0));
	assign q_merge   = q_rd_q && ram_rdata.begins && !ram_rdata.in_use;

	always_comb begin
		alu_req.op = bfpa_pkg::ALU_ADD;
		alu_req.a  = bfpa_pkg::ALU_W'(p_q);
		alu_req.b  = bfpa_pkg::ALU_W'(len_eff);
		case (state_q)
			ST_CLEAR: begin
				alu_req.b = bfpa_pkg::ALU_W'(1);
			end
			ST_ALC_COMMIT: begin
				alu_req.a = found_q ? bfpa_pkg::ALU_W'(best_q) : bfpa_pkg::ALU_W'(top_q);
				alu_req.b = bfpa_pkg::ALU_W'(rp_q);
			end
			ST_FRE_RDN: begin
				alu_req.a = bfpa_pkg::ALU_W'(len_p_q);
			end
			ST_FRE_SRCH: begin
				if (q_stop) begin
					alu_req.a = bfpa_pkg::ALU_W'(len_eff);
					alu_req.b = bfpa_pkg::ALU_W'(len_p_q);
				end else begin
					alu_req.op = bfpa_pkg::ALU_SUB;
					alu_req.a  = bfpa_pkg::ALU_W'(q_q);
					alu_req.b  = bfpa_pkg::ALU_W'(1);
				end
			end
			ST_FRE_TOP: begin
				alu_req.b = bfpa_pkg::ALU_W'(len_p_q);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		ram_raddr = p_idx;
		ram_we    = 1'b0;
		ram_waddr = p_idx;
		ram_wdata = '0;
		case (state_q)
			ST_IDLE: begin
				ram_raddr = (req.func == bfpa_pkg::FUNC_FREE) ? pg_idx : '0;
			end
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_ALC_SCAN: begin
				ram_raddr = y_idx;
			end
			ST_ALC_COMMIT: begin
				ram_we           = found_q || !heap_full;
				ram_waddr        = found_q ? best_q : top_idx;
				ram_wdata.begins = 1'b1;
				ram_wdata.in_use = 1'b1;
				ram_wdata.pages  = rp_q;
			end
			ST_ALC_SPLIT: begin
				ram_we           = 1'b1;
				ram_wdata.begins = 1'b1;
				ram_wdata.pages  = spare_q;
			end
			ST_FRE_RDP: begin
				ram_raddr = y_idx;
			end
			ST_FRE_RDN: begin
				ram_we    = n_ok;
				ram_waddr = n_q;
			end
			ST_FRE_SRCH: begin
				ram_raddr = y_idx;
				ram_we    = q_merge;
			end
			ST_FRE_TOP: begin
				ram_we = 1'b1;
				if (!walk_end) begin
					ram_wdata.begins = 1'b1;
					ram_wdata.pages  = len_p_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			top_q        <= '0;
			p_q          <= '0;
			rp_q         <= '0;
			spare_q      <= '0;
			len_p_q      <= '0;
			best_q       <= '0;
			n_q          <= '0;
			q_q          <= '0;
			q_rd_q       <= 1'b0;
			n_end_q      <= 1'b0;
			found_q      <= 1'b0;
			res_addr_q   <= '0;
			res_status_q <= bfpa_pkg::STATUS_OK;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall && (state_q != ST_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					p_q <= alu_y[bfpa_pkg::LEN_W-1:0];
					if (p_q == bfpa_pkg::LEN_W'(bfpa_pkg::MAX_PAGES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						res_addr_q   <= '0;
						res_status_q <= bfpa_pkg::STATUS_OK;
						if (req.func == bfpa_pkg::FUNC_ALLOC) begin
							if (need_oom) begin
								res_status_q <= bfpa_pkg::STATUS_OOM;
								state_q      <= ST_DONE;
							end else begin
								rp_q    <= rp_in;
								found_q <= 1'b0;
								p_q     <= '0;
								state_q <= (top_q == '0) ? ST_ALC_COMMIT : ST_ALC_SCAN;
							end
						end else if (addr_ok) begin
							p_q     <= bfpa_pkg::LEN_W'(pg_idx);
							state_q <= ST_FRE_RDP;
						end else begin
							res_status_q <= bfpa_pkg::STATUS_BAD_FREE;
							state_q      <= ST_DONE;
						end
					end
				end
				ST_ALC_SCAN: begin
					if (better) begin
						found_q <= 1'b1;
						best_q  <= p_idx;
						spare_q <= spare_w;
					end
					p_q <= alu_y[bfpa_pkg::LEN_W-1:0];
					if (walk_end) begin
						state_q <= ST_ALC_COMMIT;
					end
				end
				ST_ALC_COMMIT: begin
					if (found_q) begin
						res_addr_q <= bfpa_pkg::payload_of(best_q);
						if (spare_q != '0) begin
							p_q     <= alu_y[bfpa_pkg::LEN_W-1:0];
							state_q <= ST_ALC_SPLIT;
						end else begin
							state_q <= ST_DONE;
						end
					end else if (heap_full) begin
						res_status_q <= bfpa_pkg::STATUS_OOM;
						state_q      <= ST_DONE;
					end else begin
						top_q      <= alu_y[bfpa_pkg::LEN_W-1:0];
						res_addr_q <= bfpa_pkg::payload_of(top_idx);
						state_q    <= ST_DONE;
					end
				end
				ST_ALC_SPLIT: begin
					state_q <= ST_DONE;
				end
				ST_FRE_RDP: begin
					if (!p_live) begin
						res_status_q <= bfpa_pkg::STATUS_BAD_FREE;
						state_q      <= ST_DONE;
					end else begin
						len_p_q <= len_eff;
						n_q     <= y_idx;
						n_end_q <= walk_end;
						state_q <= ST_FRE_RDN;
					end
				end
				ST_FRE_RDN: begin
					if (n_ok) begin
						len_p_q <= alu_y[bfpa_pkg::LEN_W-1:0];
					end
					q_q     <= p_idx;
					q_rd_q  <= 1'b0;
					state_q <= (p_q == '0) ? ST_FRE_TOP : ST_FRE_SRCH;
				end
				ST_FRE_SRCH: begin
					if (q_stop) begin
						if (q_merge) begin
							p_q     <= bfpa_pkg::LEN_W'(q_q);
							len_p_q <= alu_y[bfpa_pkg::LEN_W-1:0];
						end
						state_q <= ST_FRE_TOP;
					end else begin
						q_q    <= y_idx;
						q_rd_q <= 1'b1;
					end
				end
				ST_FRE_TOP: begin
					// free tail chunk goes back above the heap top
					if (walk_end) begin
						top_q <= p_q;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q.result_address <= res_addr_q;
						rsp_q.status         <= res_status_q;
						rsp_valid_q          <= 1'b1;
						state_q              <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`ASSERT_AR(a_accept_leaves_idle, clk, arst_n, (req_valid && !req_stall) |=> (state_q != ST_IDLE))
	`ASSERT_AR(a_scan_in_heap, clk, arst_n, (state_q == ST_ALC_SCAN) |-> (p_q < top_q))
	`ASSERT_AR(a_search_below_p, clk, arst_n, (state_q == ST_FRE_SRCH) |-> (bfpa_pkg::LEN_W'(q_q) <= p_q))
	`ASSERT_AR(a_oom_zero_addr, clk, arst_n, (rsp_valid && (rsp.status == bfpa_pkg::STATUS_OOM)) |-> (rsp.result_address == '0))
	`ASSERT_NR(a_top_bounded, clk, !arst_n || (top_q <= bfpa_pkg::LEN_W'(bfpa_pkg::MAX_PAGES)))
endmodule
